// File: rtl/xdfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_pkg
// Types and codes shared by the XOR-delta frame decoder.
// ----------------------------------------------------------------------------
package xdfd_pkg;

	localparam int CountBits = 14;
	localparam int OutOffBits = 16;

	typedef enum logic [6:0] {
		PH_CMD       = 7'b0000001,
		PH_SFILL_CNT = 7'b0000010,
		PH_SFILL_VAL = 7'b0000100,
		PH_LITERAL   = 7'b0001000,
		PH_WORD_LO   = 7'b0010000,
		PH_WORD_HI   = 7'b0100000,
		PH_LFILL_VAL = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		OP_XOR_BYTE = 2'd0,
		OP_XOR_FILL = 2'd1,
		OP_END      = 2'd2
	} op_kind_t;

	typedef struct packed {
		phase_t               phase;
		logic [CountBits-1:0] remaining;
		logic [7:0]           word_lo;
	} parse_state_t;

	typedef struct packed {
		op_kind_t              op_kind;
		logic [OutOffBits-1:0] dest_offset;
		logic [CountBits-1:0]  run_length;
		logic [7:0]            xor_value;
		logic [OutOffBits-1:0] decoded_length;
	} result_t;

endpackage

// File: rtl/xor_delta_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_delta_frame_decoder_top
// Byte-serial XOR-delta frame decoder producing XOR commands.
// ----------------------------------------------------------------------------
// Input channel: one encoded byte per word on src_byte (in_valid/in_ready).
// Output channel: one command word (out_valid/out_ready) carrying op_kind,
// dest_offset, run_length, xor_value and decoded_length. A byte yields zero
// or one command: literal bytes give single-byte XORs, fills give one run,
// a zero command word gives the end-of-frame word with the final offset.
// Skips and zero-length runs give nothing.
// A command appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the parser state is updated in the same
// cycle the byte is taken, and the single output register is the only stage.
// A new byte is taken whenever the output register is empty or being read,
// so a stalled receiver holds the command and stops input only then.
// Reset clears the parser to expect a command byte, zeroes the offset and
// empties the output register.
// ----------------------------------------------------------------------------
module xor_delta_frame_decoder_top #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  op_kind,
	output logic [15:0] dest_offset,
	output logic [13:0] run_length,
	output logic [7:0]  xor_value,
	output logic [15:0] decoded_length
);

	xdfd_pkg::parse_state_t state_q, state_nxt;
	logic [OFFSET_BITS-1:0] offset_q, offset_nxt;
	logic                   emit;
	xdfd_pkg::result_t      res, res_q;
	logic                   out_valid_q;
	logic                   take;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	xdfd_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.cur        (state_q),
		.offset     (offset_q),
		.src_byte   (src_byte),
		.nxt        (state_nxt),
		.offset_nxt (offset_nxt),
		.emit       (emit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= xdfd_pkg::PH_CMD;
			state_q.remaining <= '0;
			state_q.word_lo   <= '0;
			offset_q          <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (take) begin
				state_q  <= state_nxt;
				offset_q <= offset_nxt;
			end
			if (in_ready) begin
				out_valid_q <= take && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign op_kind        = res_q.op_kind;
	assign dest_offset    = res_q.dest_offset;
	assign run_length     = res_q.run_length;
	assign xor_value      = res_q.xor_value;
	assign decoded_length = res_q.decoded_length;

`ifndef SYNTHESIS
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.op_kind == xdfd_pkg::OP_END
		|-> res_q.dest_offset == '0 && res_q.run_length == '0 && res_q.xor_value == '0)
		else $error("end word carries non-zero command fields");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.op_kind == xdfd_pkg::OP_XOR_BYTE
		|-> res_q.run_length == 14'd1 && res_q.decoded_length == '0)
		else $error("single-byte XOR with bad length fields");

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.op_kind == xdfd_pkg::OP_XOR_FILL
		|-> res_q.run_length != '0 && res_q.decoded_length == '0)
		else $error("zero-length fill emitted");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && res.op_kind == xdfd_pkg::OP_END |=> offset_q == '0)
		else $error("offset not cleared after end of frame");

	a_lit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == xdfd_pkg::PH_LITERAL |-> state_q.remaining != '0)
		else $error("literal phase with no bytes left");
`endif

endmodule

// File: rtl/xdfd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdfd_step
// Next-state and command decode for one encoded byte.
// ----------------------------------------------------------------------------
module xdfd_step #(
	parameter int OFFSET_BITS = 16
) (
	input  xdfd_pkg::parse_state_t  cur,
	input  logic [OFFSET_BITS-1:0]  offset,
	input  logic [7:0]              src_byte,
	output xdfd_pkg::parse_state_t  nxt,
	output logic [OFFSET_BITS-1:0]  offset_nxt,
	output logic                    emit,
	output xdfd_pkg::result_t       res
);

	localparam int PadShort = OFFSET_BITS - 7;
	localparam int PadSkip  = OFFSET_BITS - 15;
	localparam int PadCount = OFFSET_BITS - xdfd_pkg::CountBits;

	logic [15:0]                      word;
	logic [xdfd_pkg::CountBits-1:0]   lit_left;
	logic [OFFSET_BITS-1:0]           rem_ext;

	assign word     = {src_byte, cur.word_lo};
	assign lit_left = cur.remaining - xdfd_pkg::CountBits'(1);
	assign rem_ext  = {{PadCount{1'b0}}, cur.remaining};

	always_comb begin
		nxt        = cur;
		offset_nxt = offset;
		emit       = 1'b0;
		res        = '0;
		res.op_kind = xdfd_pkg::OP_XOR_BYTE;
		case (cur.phase)
			xdfd_pkg::PH_SFILL_CNT: begin
				nxt.remaining = {6'd0, src_byte};
				nxt.phase     = xdfd_pkg::PH_SFILL_VAL;
			end
			xdfd_pkg::PH_SFILL_VAL, xdfd_pkg::PH_LFILL_VAL: begin
				nxt.phase = xdfd_pkg::PH_CMD;
				if (cur.remaining != '0) begin
					emit            = 1'b1;
					res.op_kind     = xdfd_pkg::OP_XOR_FILL;
					res.dest_offset = offset[15:0];
					res.run_length  = cur.remaining;
					res.xor_value   = src_byte;
					offset_nxt      = offset + rem_ext;
					nxt.remaining   = '0;
				end
			end
			xdfd_pkg::PH_LITERAL: begin
				emit            = 1'b1;
				res.op_kind     = xdfd_pkg::OP_XOR_BYTE;
				res.dest_offset = offset[15:0];
				res.run_length  = xdfd_pkg::CountBits'(1);
				res.xor_value   = src_byte;
				offset_nxt      = offset + OFFSET_BITS'(1);
				nxt.remaining   = lit_left;
				if (lit_left == '0) begin
					nxt.phase = xdfd_pkg::PH_CMD;
				end
			end
			xdfd_pkg::PH_WORD_LO: begin
				nxt.word_lo = src_byte;
				nxt.phase   = xdfd_pkg::PH_WORD_HI;
			end
			xdfd_pkg::PH_WORD_HI: begin
				nxt.word_lo = '0;
				nxt.phase   = xdfd_pkg::PH_CMD;
				if (word == 16'd0) begin
					emit               = 1'b1;
					res.op_kind        = xdfd_pkg::OP_END;
					res.decoded_length = offset[15:0];
					offset_nxt         = '0;
				end else if (!word[15]) begin
					offset_nxt = offset + {{PadSkip{1'b0}}, word[14:0]};
				end else if (!word[14]) begin
					nxt.remaining = word[13:0];
					if (word[13:0] != '0) begin
						nxt.phase = xdfd_pkg::PH_LITERAL;
					end
				end else begin
					nxt.remaining = word[13:0];
					nxt.phase     = xdfd_pkg::PH_LFILL_VAL;
				end
			end
			default: begin
				// command byte
				nxt.phase = xdfd_pkg::PH_CMD;
				if (!src_byte[7]) begin
					if (src_byte[6:0] == '0) begin
						nxt.phase = xdfd_pkg::PH_SFILL_CNT;
					end else begin
						nxt.remaining = {7'd0, src_byte[6:0]};
						nxt.phase     = xdfd_pkg::PH_LITERAL;
					end
				end else if (src_byte[6:0] == '0) begin
					nxt.phase = xdfd_pkg::PH_WORD_LO;
				end else begin
					offset_nxt = offset + {{PadShort{1'b0}}, src_byte[6:0]};
				end
			end
		endcase
	end

endmodule
